>>> rtl/core/hslp_pkg.sv
// hslp_pkg: shared types, codes and character helpers for the HTTP start-line parser.
// Used by hslp_step and http_start_line_parser. No dependencies.
package hslp_pkg;

  localparam int METHOD_LIMIT_DEF = 32;
  localparam int URI_LIMIT_DEF    = 256;
  localparam int REASON_LIMIT_DEF = 256;

  localparam int PROTO_TEXT_W = 56;
  localparam int PROTO_LEN_W  = 3;
  localparam int LINE_W       = 12;

  localparam logic [PROTO_TEXT_W-1:0] PROTO_TEXT_RST = 56'd1347703880;
  localparam logic [PROTO_LEN_W-1:0]  PROTO_LEN_RST  = 3'd4;
  localparam logic [LINE_W-1:0]       LINE_MAX       = '1;

  // configuration register indexes
  localparam logic CFG_PROTO_TEXT = 1'b0;
  localparam logic CFG_PROTO_LEN  = 1'b1;

  // request role tags
  localparam logic [1:0] RTAG_NONE   = 2'd0;
  localparam logic [1:0] RTAG_METHOD = 2'd1;
  localparam logic [1:0] RTAG_URI    = 2'd2;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_HT    = 8'h09;
  localparam logic [7:0] CH_DEL   = 8'h7F;

  typedef enum logic [13:0] {
    PH_PROTO  = 14'b00000000000001,
    PH_SLASH  = 14'b00000000000010,
    PH_MAJ0   = 14'b00000000000100,
    PH_MAJ    = 14'b00000000001000,
    PH_MIN0   = 14'b00000000010000,
    PH_MIN    = 14'b00000000100000,
    PH_CODE   = 14'b00000001000000,
    PH_REASON = 14'b00000010000000,
    PH_LF     = 14'b00000100000000,
    PH_METHOD = 14'b00001000000000,
    PH_URI    = 14'b00010000000000,
    PH_DONE   = 14'b00100000000000,
    PH_FAIL   = 14'b01000000000000,
    PH_IDLE   = 14'b10000000000000
  } phase_t;

  typedef enum logic [2:0] {
    VERDICT_PENDING = 3'd0,
    VERDICT_REQUEST = 3'd1,
    VERDICT_STATUS  = 3'd2,
    VERDICT_INVALID = 3'd3,
    VERDICT_IDLE    = 3'd4
  } verdict_t;

  typedef struct packed {
    logic [1:0]        rtag;
    logic              ntag;
    verdict_t          verdict;
    logic [7:0]        maj;
    logic [7:0]        min;
    logic [15:0]       code;
    logic [LINE_W-1:0] len;
  } hslp_res_t;

  typedef struct packed {
    phase_t     ph;
    logic [2:0] pos;
    logic [7:0] maj;
    logic [7:0] min;
  } ver_st_t;

  function automatic logic is_dec_char(input logic [7:0] b);
    return (b >= CH_ZERO) && (b <= CH_NINE);
  endfunction

  function automatic logic is_ctl(input logic [7:0] b);
    return (b < CH_SP) || (b == CH_DEL);
  endfunction

  function automatic logic is_sep(input logic [7:0] b);
    return b inside {8'h28, 8'h29, 8'h3C, 8'h3E, 8'h40, 8'h2C, 8'h3B, 8'h3A, 8'h5C,
                     8'h22, CH_SLASH, 8'h5B, 8'h5D, 8'h3F, 8'h3D, 8'h7B, 8'h7D,
                     CH_SP, CH_HT};
  endfunction

  function automatic logic is_token(input logic [7:0] b);
    return !b[7] && !is_ctl(b) && !is_sep(b);
  endfunction

  function automatic logic [7:0] sat8(input logic [7:0] v, input logic [7:0] b);
    logic [7:0]  d;
    logic [11:0] n;
    d = b - CH_ZERO;
    n = ({4'b0, v} << 3) + ({4'b0, v} << 1) + {8'b0, d[3:0]};
    return (n > 12'd255) ? 8'hFF : n[7:0];
  endfunction

  function automatic logic [15:0] sat16(input logic [15:0] v, input logic [7:0] b);
    logic [7:0]  d;
    logic [19:0] n;
    d = b - CH_ZERO;
    n = ({4'b0, v} << 3) + ({4'b0, v} << 1) + {16'b0, d[3:0]};
    return (n > 20'd65535) ? 16'hFFFF : n[15:0];
  endfunction

  // protocol/major.minor, then term moves to phase after
  function automatic ver_st_t version_step(input ver_st_t st, input logic [7:0] b,
                                           input logic [PROTO_LEN_W-1:0] plen,
                                           input logic [PROTO_TEXT_W-1:0] ptext,
                                           input logic [7:0] term, input phase_t after);
    ver_st_t     r;
    logic [63:0] txt;
    logic [7:0]  c;
    r   = st;
    txt = {8'h00, ptext};
    c   = txt[{st.pos, 3'b000} +: 8];
    case (st.ph)
      PH_PROTO: begin
        if (st.pos < plen) begin
          if (b != c) begin
            r.ph = PH_FAIL;
          end else begin
            r.pos = st.pos + 3'd1;
            r.ph  = (r.pos >= plen) ? PH_SLASH : PH_PROTO;
          end
        end else begin
          r.ph = (b == CH_SLASH) ? PH_MAJ0 : PH_FAIL;
        end
      end
      PH_SLASH: r.ph = (b == CH_SLASH) ? PH_MAJ0 : PH_FAIL;
      PH_MAJ0: begin
        if (is_dec_char(b)) begin
          r.maj = sat8(8'd0, b);
          r.ph  = PH_MAJ;
        end else begin
          r.ph = PH_FAIL;
        end
      end
      PH_MAJ: begin
        if (is_dec_char(b)) r.maj = sat8(st.maj, b);
        else r.ph = (b == CH_DOT) ? PH_MIN0 : PH_FAIL;
      end
      PH_MIN0: begin
        if (is_dec_char(b)) begin
          r.min = sat8(8'd0, b);
          r.ph  = PH_MIN;
        end else begin
          r.ph = PH_FAIL;
        end
      end
      PH_MIN: begin
        if (is_dec_char(b)) r.min = sat8(st.min, b);
        else r.ph = (b == term) ? after : PH_FAIL;
      end
      default: r.ph = PH_FAIL;
    endcase
    return r;
  endfunction

endpackage

>>> rtl/core/hslp_step.sv
// hslp_step: line state of both hypotheses and the per-byte step logic.
// Depends on hslp_pkg. Result is combinational; state advances on step_en.
module hslp_step
  import hslp_pkg::*;
#(
  parameter int METHOD_LIMIT = METHOD_LIMIT_DEF,
  parameter int URI_LIMIT    = URI_LIMIT_DEF,
  parameter int REASON_LIMIT = REASON_LIMIT_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    step_en,
  input  logic [7:0]              data_byte,
  input  logic                    message_start,
  input  logic [PROTO_TEXT_W-1:0] proto_text,
  input  logic [PROTO_LEN_W-1:0]  proto_len,
  output hslp_res_t               res
);

  localparam int MW = $clog2(METHOD_LIMIT);
  localparam int UW = $clog2(URI_LIMIT);
  localparam int RW = $clog2(REASON_LIMIT);
  localparam logic [MW-1:0] METHOD_MAX = MW'(METHOD_LIMIT - 1);
  localparam logic [UW-1:0] URI_MAX    = UW'(URI_LIMIT - 1);
  localparam logic [RW-1:0] REASON_MAX = RW'(REASON_LIMIT - 1);

  phase_t            sph_r, sph_nxt, rph_r, rph_nxt;
  logic [2:0]        spos_r, spos_nxt, rpos_r, rpos_nxt;
  logic [7:0]        smaj_r, smaj_nxt, smin_r, smin_nxt;
  logic [7:0]        rmaj_r, rmaj_nxt, rmin_r, rmin_nxt;
  logic [15:0]       code_r, code_nxt;
  logic [MW-1:0]     mcnt_r, mcnt_nxt;
  logic [UW-1:0]     ucnt_r, ucnt_nxt;
  logic [RW-1:0]     ncnt_r, ncnt_nxt;
  logic [LINE_W-1:0] len_r, len_nxt;

  ver_st_t           sv_cur, sv_new, rv_cur, rv_new;
  phase_t            sp, rp;
  logic [15:0]       code_c;
  logic [MW-1:0]     mcnt_c;
  logic [UW-1:0]     ucnt_c;
  logic [RW-1:0]     ncnt_c;
  logic [LINE_W-1:0] len_c;
  logic              idle;

  always_comb begin
    // message start clears the line before the byte is taken
    sv_cur = message_start ? ver_st_t'{PH_PROTO, 3'd0, 8'd0, 8'd0}
                           : ver_st_t'{sph_r, spos_r, smaj_r, smin_r};
    rv_cur = message_start ? ver_st_t'{PH_METHOD, 3'd0, 8'd0, 8'd0}
                           : ver_st_t'{rph_r, rpos_r, rmaj_r, rmin_r};
    code_c = message_start ? 16'd0 : code_r;
    mcnt_c = message_start ? '0 : mcnt_r;
    ucnt_c = message_start ? '0 : ucnt_r;
    ncnt_c = message_start ? '0 : ncnt_r;
    len_c  = message_start ? '0 : len_r;
    idle   = (sv_cur.ph == PH_IDLE);

    res         = '0;
    res.verdict = VERDICT_PENDING;

    sph_nxt  = sv_cur.ph;
    spos_nxt = sv_cur.pos;
    smaj_nxt = sv_cur.maj;
    smin_nxt = sv_cur.min;
    rph_nxt  = rv_cur.ph;
    rpos_nxt = rv_cur.pos;
    rmaj_nxt = rv_cur.maj;
    rmin_nxt = rv_cur.min;
    code_nxt = code_c;
    mcnt_nxt = mcnt_c;
    ucnt_nxt = ucnt_c;
    ncnt_nxt = ncnt_c;
    len_nxt  = (len_c != LINE_MAX) ? len_c + 1'b1 : len_c;

    sv_new = version_step(sv_cur, data_byte, proto_len, proto_text, CH_SP, PH_CODE);
    rv_new = version_step(rv_cur, data_byte, proto_len, proto_text, CH_CR, PH_LF);

    sp = sv_cur.ph;
    case (sv_cur.ph)
      PH_CODE: begin
        if (is_dec_char(data_byte)) code_nxt = sat16(code_c, data_byte);
        else sp = (data_byte == CH_SP) ? PH_REASON : PH_FAIL;
      end
      PH_REASON: begin
        if (!is_ctl(data_byte)) begin
          if (ncnt_c < REASON_MAX) begin
            ncnt_nxt = ncnt_c + 1'b1;
            res.ntag = 1'b1;
          end else begin
            sp = PH_FAIL;
          end
        end else begin
          sp = (data_byte == CH_CR) ? PH_LF : PH_FAIL;
        end
      end
      PH_LF:   sp = (data_byte == CH_LF) ? PH_DONE : PH_FAIL;
      PH_DONE: sp = PH_DONE;
      PH_FAIL: sp = PH_FAIL;
      default: begin
        sp       = sv_new.ph;
        spos_nxt = sv_new.pos;
        smaj_nxt = sv_new.maj;
        smin_nxt = sv_new.min;
      end
    endcase

    rp = rv_cur.ph;
    case (rv_cur.ph)
      PH_METHOD: begin
        if (is_token(data_byte)) begin
          if (mcnt_c < METHOD_MAX) begin
            mcnt_nxt = mcnt_c + 1'b1;
            res.rtag = RTAG_METHOD;
          end else begin
            rp = PH_FAIL;
          end
        end else begin
          rp = (data_byte == CH_SP && mcnt_c != '0) ? PH_URI : PH_FAIL;
        end
      end
      PH_URI: begin
        if (!is_ctl(data_byte) && data_byte != CH_SP) begin
          if (ucnt_c < URI_MAX) begin
            ucnt_nxt = ucnt_c + 1'b1;
            res.rtag = RTAG_URI;
          end else begin
            rp = PH_FAIL;
          end
        end else begin
          rp = (data_byte == CH_SP && ucnt_c != '0) ? PH_PROTO : PH_FAIL;
        end
      end
      PH_LF:   rp = (data_byte == CH_LF) ? PH_DONE : PH_FAIL;
      PH_DONE: rp = PH_DONE;
      PH_FAIL: rp = PH_FAIL;
      default: begin
        rp       = rv_new.ph;
        rpos_nxt = rv_new.pos;
        rmaj_nxt = rv_new.maj;
        rmin_nxt = rv_new.min;
      end
    endcase

    sph_nxt = sp;
    rph_nxt = rp;
    if (sp == PH_DONE) begin
      res.verdict = VERDICT_STATUS;
      res.maj     = smaj_nxt;
      res.min     = smin_nxt;
      res.code    = code_nxt;
      res.len     = len_nxt;
    end else if (rp == PH_DONE) begin
      res.verdict = VERDICT_REQUEST;
      res.maj     = rmaj_nxt;
      res.min     = rmin_nxt;
      res.len     = len_nxt;
    end else if (sp == PH_FAIL && rp == PH_FAIL) begin
      res.verdict = VERDICT_INVALID;
      res.len     = len_nxt;
    end
    if (res.verdict != VERDICT_PENDING) begin
      sph_nxt = PH_IDLE;
      rph_nxt = PH_IDLE;
    end

    if (idle) begin
      res         = '0;
      res.verdict = VERDICT_IDLE;
      sph_nxt     = sv_cur.ph;
      spos_nxt    = sv_cur.pos;
      smaj_nxt    = sv_cur.maj;
      smin_nxt    = sv_cur.min;
      rph_nxt     = rv_cur.ph;
      rpos_nxt    = rv_cur.pos;
      rmaj_nxt    = rv_cur.maj;
      rmin_nxt    = rv_cur.min;
      code_nxt    = code_c;
      mcnt_nxt    = mcnt_c;
      ucnt_nxt    = ucnt_c;
      ncnt_nxt    = ncnt_c;
      len_nxt     = len_c;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sph_r  <= PH_PROTO;
      rph_r  <= PH_METHOD;
      spos_r <= '0;
      rpos_r <= '0;
      smaj_r <= '0;
      smin_r <= '0;
      rmaj_r <= '0;
      rmin_r <= '0;
      code_r <= '0;
      mcnt_r <= '0;
      ucnt_r <= '0;
      ncnt_r <= '0;
      len_r  <= '0;
    end else if (step_en) begin
      sph_r  <= sph_nxt;
      rph_r  <= rph_nxt;
      spos_r <= spos_nxt;
      rpos_r <= rpos_nxt;
      smaj_r <= smaj_nxt;
      smin_r <= smin_nxt;
      rmaj_r <= rmaj_nxt;
      rmin_r <= rmin_nxt;
      code_r <= code_nxt;
      mcnt_r <= mcnt_nxt;
      ucnt_r <= ucnt_nxt;
      ncnt_r <= ncnt_nxt;
      len_r  <= len_nxt;
    end
  end

endmodule

>>> rtl/core/http_start_line_parser.sv
// http_start_line_parser: top level with input register, output register and config.
// Depends on hslp_pkg and hslp_step.
//
// Usage:
//   in_*  : one message byte per transfer; in_tuser marks the first byte of a
//           message and restarts the parser before that byte is taken.
//   out_* : exactly one result per accepted byte: the echoed byte, its role
//           tags and a verdict (pending, request, status, invalid, idle), plus line
//           length (request, status, invalid), version (request, status), code (status).
//   cfg_* : protocol identifier text (index 0) and its length (index 1);
//           always ready, write while the stream is quiet.
// Path: an accepted byte waits in the input register, then moves to the output register.
// Throughput: one byte per cycle while out_tready stays high; the step logic
// between the input register and the output register is combinational.
// Reset: both hypotheses restart, config returns to "HTTP" with length 4,
// and both registers empty.
// Stall: while out_tready is low the result holds; one more byte waits in
// the input register, then in_tready drops until the result is taken.
module http_start_line_parser
  import hslp_pkg::*;
#(
  parameter int METHOD_LIMIT = METHOD_LIMIT_DEF,
  parameter int URI_LIMIT    = URI_LIMIT_DEF,
  parameter int REASON_LIMIT = REASON_LIMIT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tuser,   // [0] message_start
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // [7:0] echo_byte, [10:8] verdict, [18:11] major_version,
                                  // [26:19] minor_version, [42:27] status_code,
                                  // [54:43] line_length
  output logic [2:0]  out_tuser,  // [1:0] request_tag, [2] reason_tag
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [55:0] cfg_data
);

  logic                    in_vld_r, out_vld_r;
  logic [7:0]              in_byte_r, out_byte_r;
  logic                    in_start_r;
  hslp_res_t               out_res_r, step_res;
  logic [PROTO_TEXT_W-1:0] ptext_r;
  logic [PROTO_LEN_W-1:0]  plen_r;
  logic                    move;

  assign move      = in_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !in_vld_r || move;
  assign cfg_ready = 1'b1;

  hslp_step #(
    .METHOD_LIMIT (METHOD_LIMIT),
    .URI_LIMIT    (URI_LIMIT),
    .REASON_LIMIT (REASON_LIMIT)
  ) u_step (
    .clk           (clk),
    .rst_n         (rst_n),
    .step_en       (move),
    .data_byte     (in_byte_r),
    .message_start (in_start_r),
    .proto_text    (ptext_r),
    .proto_len     (plen_r),
    .res           (step_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r  <= in_tdata;
      in_start_r <= in_tuser;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (move) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      out_byte_r <= in_byte_r;
      out_res_r  <= step_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptext_r <= PROTO_TEXT_RST;
      plen_r  <= PROTO_LEN_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_PROTO_TEXT: ptext_r <= cfg_data;
        CFG_PROTO_LEN:  plen_r  <= cfg_data[PROTO_LEN_W-1:0];
        default:        ptext_r <= ptext_r;
      endcase
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {1'b0, out_res_r.len, out_res_r.code, out_res_r.min, out_res_r.maj,
                       out_res_r.verdict, out_byte_r};
  assign out_tuser  = {out_res_r.ntag, out_res_r.rtag};

`ifndef ASSERT_OFF
  a_code_only_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_res_r.verdict != VERDICT_STATUS |-> out_res_r.code == 16'd0)
    else $error("status code outside a status verdict");

  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_res_r.verdict == VERDICT_IDLE |->
      out_res_r.rtag == RTAG_NONE && !out_res_r.ntag && out_res_r.len == '0)
    else $error("idle result carries tags or length");

  a_no_double_tag: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_res_r.ntag |-> out_res_r.verdict == VERDICT_PENDING ||
      out_res_r.verdict == VERDICT_REQUEST || out_res_r.verdict == VERDICT_INVALID)
    else $error("reason byte closes a status line");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_vld_r |-> in_tready)
    else $error("input stalled with empty output register");
`endif

endmodule

>>> test/tb.sv
// tb: self-checking bench for http_start_line_parser, one byte per transfer.
// A scoreboard class predicts every result and checks it in order of arrival.
// Depends on hslp_pkg and the parser RTL only.
module tb
  import hslp_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    phase_t ph;
    int     pos;
    int     maj;
    int     mnr;
  } ver_track_t;

  typedef struct packed {
    logic [7:0]  echo;
    logic [1:0]  rtag;
    logic        ntag;
    verdict_t    verdict;
    logic [7:0]  maj;
    logic [7:0]  mnr;
    logic [15:0] code;
    logic [11:0] len;
  } line_result_t;

  class start_line_scoreboard;
    logic [55:0]  proto_text;
    logic [2:0]   proto_len;
    ver_track_t   st_v;
    ver_track_t   rq_v;
    int           code_v, meth_n, uri_n, reason_n, line_n;
    line_result_t pending[$];
    int           errors;

    function new();
      proto_text = PROTO_TEXT_RST;
      proto_len  = PROTO_LEN_RST;
      errors     = 0;
      clear_line();
    endfunction

    function void clear_line();
      st_v = '{PH_PROTO, 0, 0, 0};
      rq_v = '{PH_METHOD, 0, 0, 0};
      code_v   = 0;
      meth_n   = 0;
      uri_n    = 0;
      reason_n = 0;
      line_n   = 0;
    endfunction

    function void set_config(logic idx, logic [55:0] val);
      if (idx == CFG_PROTO_TEXT) proto_text = val;
      else proto_len = val[2:0];
    endfunction

    function bit is_num(logic [7:0] b);
      return b >= CH_ZERO && b <= CH_NINE;
    endfunction

    function bit is_ctl_char(logic [7:0] b);
      return b < CH_SP || b == CH_DEL;
    endfunction

    function bit is_sep_char(logic [7:0] b);
      case (b)
        "(", ")", "<", ">", "@", ",", ";", ":", "\\", "\"", "/", "[", "]", "?", "=",
        "{", "}", CH_SP, CH_HT: return 1;
        default: return 0;
      endcase
    endfunction

    function bit is_tok_char(logic [7:0] b);
      return b < 8'h80 && !is_ctl_char(b) && !is_sep_char(b);
    endfunction

    function int dec_sat(int v, logic [7:0] b, int lim);
      int n;
      n = v * 10 + int'(b - CH_ZERO);
      return (v > lim || n > lim) ? lim : n;
    endfunction

    // protocol/major.minor, then stop_ch moves on to next_ph
    function ver_track_t version_advance(ver_track_t v, logic [7:0] b,
                                         logic [7:0] stop_ch, phase_t next_ph);
      ver_track_t r;
      r = v;
      case (v.ph)
        PH_PROTO: begin
          if (v.pos < proto_len) begin
            if (b != proto_text[8*v.pos +: 8]) begin
              r.ph = PH_FAIL;
            end else begin
              r.pos = v.pos + 1;
              r.ph  = (r.pos >= proto_len) ? PH_SLASH : PH_PROTO;
            end
          end else begin
            r.ph = (b == CH_SLASH) ? PH_MAJ0 : PH_FAIL;
          end
        end
        PH_SLASH: r.ph = (b == CH_SLASH) ? PH_MAJ0 : PH_FAIL;
        PH_MAJ0: begin
          if (is_num(b)) begin
            r.maj = int'(b - CH_ZERO);
            r.ph  = PH_MAJ;
          end else begin
            r.ph = PH_FAIL;
          end
        end
        PH_MAJ: begin
          if (is_num(b)) r.maj = dec_sat(v.maj, b, 255);
          else r.ph = (b == CH_DOT) ? PH_MIN0 : PH_FAIL;
        end
        PH_MIN0: begin
          if (is_num(b)) begin
            r.mnr = int'(b - CH_ZERO);
            r.ph  = PH_MIN;
          end else begin
            r.ph = PH_FAIL;
          end
        end
        PH_MIN: begin
          if (is_num(b)) r.mnr = dec_sat(v.mnr, b, 255);
          else r.ph = (b == stop_ch) ? next_ph : PH_FAIL;
        end
        default: r.ph = PH_FAIL;
      endcase
      return r;
    endfunction

    function void note_input(logic [7:0] b, logic start);
      line_result_t e;
      phase_t       sp, rp;
      e = '0;
      e.echo = b;
      e.verdict = VERDICT_PENDING;
      if (start) clear_line();
      if (st_v.ph == PH_IDLE) begin
        e.verdict = VERDICT_IDLE;
      end else begin
        if (line_n < 4095) line_n++;

        sp = st_v.ph;
        case (sp)
          PH_CODE: begin
            if (is_num(b)) code_v = dec_sat(code_v, b, 65535);
            else sp = (b == CH_SP) ? PH_REASON : PH_FAIL;
          end
          PH_REASON: begin
            if (!is_ctl_char(b)) begin
              if (reason_n < REASON_LIMIT_DEF - 1) begin
                reason_n++;
                e.ntag = 1'b1;
              end else begin
                sp = PH_FAIL;
              end
            end else begin
              sp = (b == CH_CR) ? PH_LF : PH_FAIL;
            end
          end
          PH_LF: sp = (b == CH_LF) ? PH_DONE : PH_FAIL;
          PH_DONE, PH_FAIL: ;
          default: begin
            st_v = version_advance(st_v, b, CH_SP, PH_CODE);
            sp = st_v.ph;
          end
        endcase
        st_v.ph = sp;

        rp = rq_v.ph;
        case (rp)
          PH_METHOD: begin
            if (is_tok_char(b)) begin
              if (meth_n < METHOD_LIMIT_DEF - 1) begin
                meth_n++;
                e.rtag = RTAG_METHOD;
              end else begin
                rp = PH_FAIL;
              end
            end else begin
              rp = (b == CH_SP && meth_n > 0) ? PH_URI : PH_FAIL;
            end
          end
          PH_URI: begin
            if (!is_ctl_char(b) && b != CH_SP) begin
              if (uri_n < URI_LIMIT_DEF - 1) begin
                uri_n++;
                e.rtag = RTAG_URI;
              end else begin
                rp = PH_FAIL;
              end
            end else begin
              rp = (b == CH_SP && uri_n > 0) ? PH_PROTO : PH_FAIL;
            end
          end
          PH_LF: rp = (b == CH_LF) ? PH_DONE : PH_FAIL;
          PH_DONE, PH_FAIL: ;
          default: begin
            rq_v = version_advance(rq_v, b, CH_CR, PH_LF);
            rp = rq_v.ph;
          end
        endcase
        rq_v.ph = rp;

        if (sp == PH_DONE) begin
          e.verdict = VERDICT_STATUS;
          e.maj = 8'(st_v.maj);
          e.mnr = 8'(st_v.mnr);
          e.code = 16'(code_v);
          e.len = 12'(line_n);
        end else if (rp == PH_DONE) begin
          e.verdict = VERDICT_REQUEST;
          e.maj = 8'(rq_v.maj);
          e.mnr = 8'(rq_v.mnr);
          e.len = 12'(line_n);
        end else if (sp == PH_FAIL && rp == PH_FAIL) begin
          e.verdict = VERDICT_INVALID;
          e.len = 12'(line_n);
        end
        if (e.verdict != VERDICT_PENDING) begin
          st_v.ph = PH_IDLE;
          rq_v.ph = PH_IDLE;
        end
      end
      pending.push_back(e);
    endfunction

    function void check_field(string name, int unsigned exp_v, int unsigned act_v);
      if (exp_v != act_v) begin
        $error("%s: expected %0d, got %0d", name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_result(logic [55:0] d, logic [2:0] u);
      line_result_t e;
      if (pending.size() == 0) begin
        $error("result transfer with no byte outstanding");
        errors++;
        return;
      end
      e = pending.pop_front();
      check_field("echo_byte", e.echo, d[7:0]);
      check_field("verdict", e.verdict, d[10:8]);
      check_field("major_version", e.maj, d[18:11]);
      check_field("minor_version", e.mnr, d[26:19]);
      check_field("status_code", e.code, d[42:27]);
      check_field("line_length", e.len, d[54:43]);
      check_field("request_tag", e.rtag, u[1:0]);
      check_field("reason_tag", e.ntag, u[2]);
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [55:0] out_tdata;
  logic [2:0]  out_tuser;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic [55:0] cfg_data;

  start_line_scoreboard sb;
  logic [7:0]           msg[$];
  bit                   no_gaps;

  http_start_line_parser i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      out_tready <= no_gaps || ($urandom_range(0, 99) >= 23);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser);
  end

  task automatic send_byte(logic [7:0] b, logic start);
    while (!no_gaps && $urandom_range(0, 99) < 23) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= start;
    do @(posedge clk); while (!in_tready);
    sb.note_input(b, start);
  endtask

  task automatic send_msg(bit start);
    foreach (msg[i]) send_byte(msg[i], start && i == 0);
    msg.delete();
  endtask

  task automatic write_cfg(logic idx, logic [55:0] val);
    in_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.set_config(idx, val);
    cfg_valid <= 1'b0;
  endtask

  task automatic push_text(string s);
    for (int i = 0; i < s.len(); i++) msg.push_back(s[i]);
  endtask

  task automatic push_line(string s);
    push_text(s);
    msg.push_back(CH_CR);
    msg.push_back(CH_LF);
  endtask

  task automatic push_repeat(logic [7:0] c, int n);
    repeat (n) msg.push_back(c);
  endtask

  task automatic push_digits(int n);
    repeat (n) msg.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
  endtask

  task automatic push_version();
    for (int i = 0; i < sb.proto_len; i++) msg.push_back(sb.proto_text[8*i +: 8]);
    msg.push_back(CH_SLASH);
    push_digits(($urandom_range(0, 15) == 0) ? 4 : $urandom_range(1, 2));
    msg.push_back(CH_DOT);
    push_digits(($urandom_range(0, 15) == 0) ? 4 : $urandom_range(1, 2));
  endtask

  // mostly well-formed lines with random content, some broken, some noise
  task automatic make_random_message(output bit start);
    int         kind;
    int         n;
    logic [7:0] c;
    string      tok;
    tok = "GETPOSTHEADabcxyz019-!#$%&'*+.^_|~";
    msg.delete();
    kind  = $urandom_range(0, 9);
    start = ($urandom_range(0, 9) != 0);
    if (kind < 4) begin
      push_version();
      msg.push_back(CH_SP);
      push_digits($urandom_range(0, 4));
      msg.push_back(CH_SP);
      n = $urandom_range(0, 16);
      repeat (n) begin
        do c = 8'($urandom_range(32, 255)); while (c == CH_DEL);
        msg.push_back(c);
      end
      push_line("");
    end else if (kind < 8) begin
      n = $urandom_range(1, 8);
      repeat (n) msg.push_back(tok[$urandom_range(0, tok.len() - 1)]);
      msg.push_back(CH_SP);
      n = $urandom_range(1, 16);
      repeat (n) begin
        do c = 8'($urandom_range(33, 255)); while (c == CH_DEL);
        msg.push_back(c);
      end
      msg.push_back(CH_SP);
      push_version();
      push_line("");
    end else begin
      n = $urandom_range(1, 12);
      repeat (n) msg.push_back(8'($urandom_range(0, 255)));
    end
    if (kind < 8 && $urandom_range(0, 3) == 0)
      msg[$urandom_range(0, msg.size() - 1)] = 8'($urandom_range(0, 255));
    if (kind < 8 && $urandom_range(0, 9) == 0) begin
      n = $urandom_range(1, msg.size());
      while (msg.size() > n) void'(msg.pop_back());
    end
    if ($urandom_range(0, 4) == 0)
      repeat ($urandom_range(1, 4)) msg.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic run_random(int target);
    int sent;
    bit start;
    sent = 0;
    while (sent < target) begin
      make_random_message(start);
      sent += msg.size();
      send_msg(start);
    end
  endtask

  initial begin
    int guard;
    sb = new();
    no_gaps = 1'b0;
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    in_tuser <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_PROTO_TEXT;
    cfg_data <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // first line without a start marker, then bytes after the verdict
    push_line("HTTP/1.1 200 OK");
    push_text("xy");
    send_msg(0);
    push_line("GET /index.html HTTP/1.0");
    send_msg(1);
    push_line("HTTP/0.9  Moved");
    send_msg(1);
    push_line("HTTP/2.0 99999999 Big");
    send_msg(1);
    push_line("HTTP/300.1000 100 Hi");
    send_msg(1);
    push_line("PUT /x HTTP/999.0");
    send_msg(1);
    push_line("hello");
    send_msg(1);
    push_line(" / HTTP/1.1");
    send_msg(1);
    push_line("GET  HTTP/1.1");
    send_msg(1);
    push_repeat("M", METHOD_LIMIT_DEF - 1);
    push_line(" / HTTP/1.1");
    send_msg(1);
    push_repeat("M", METHOD_LIMIT_DEF);
    push_line(" / HTTP/1.1");
    send_msg(1);
    no_gaps = 1'b1;
    push_text("GET /");
    push_repeat("u", URI_LIMIT_DEF - 2);
    push_line(" HTTP/1.1");
    send_msg(1);
    push_text("GET /");
    push_repeat("u", URI_LIMIT_DEF - 1);
    push_line(" HTTP/1.1");
    send_msg(1);
    no_gaps = 1'b0;
    push_text("HTTP/1.1 404 ");
    push_repeat("r", REASON_LIMIT_DEF - 1);
    push_line("");
    send_msg(1);
    push_text("HTTP/1.1 404 ");
    push_repeat("r", REASON_LIMIT_DEF);
    push_line("");
    send_msg(1);
    push_text("GET /");
    msg.push_back(8'hFF);
    msg.push_back(8'h80);
    push_line(" HTTP/1.1");
    send_msg(1);
    push_text("HTTP/1.1 200 ");
    msg.push_back(8'hC3);
    msg.push_back(8'hA9);
    push_line("");
    send_msg(1);
    push_text("HTTP/1.1 200 A");
    msg.push_back(CH_HT);
    push_line("B");
    send_msg(1);
    push_text("GET /");
    msg.push_back(CH_DEL);
    push_line(" HTTP/1.1");
    send_msg(1);
    push_text("HTTP/1.1 200 OK");
    msg.push_back(CH_CR);
    msg.push_back(CH_CR);
    msg.push_back(8'h00);
    send_msg(1);
    // restart in the middle of a line
    push_text("GET /a");
    send_msg(1);
    push_line("HTTP/1.1 204 No");
    send_msg(1);
    run_random(10);

    write_cfg(CFG_PROTO_TEXT, 56'({$urandom, $urandom}));
    write_cfg(CFG_PROTO_LEN, 56'd7);
    run_random(10);

    write_cfg(CFG_PROTO_LEN, 56'd1);
    run_random(10);

    // zero length: the slash is expected at once
    write_cfg(CFG_PROTO_LEN, 56'd0);
    push_line("/1.1 200 OK");
    send_msg(1);
    run_random(10);

    write_cfg(CFG_PROTO_TEXT, '1);
    write_cfg(CFG_PROTO_LEN, 56'd7);
    run_random(10);

    write_cfg(CFG_PROTO_TEXT, '0);
    write_cfg(CFG_PROTO_LEN, 56'd3);
    run_random(10);

    write_cfg(CFG_PROTO_TEXT, PROTO_TEXT_RST);
    write_cfg(CFG_PROTO_LEN, 56'(PROTO_LEN_RST));
    run_random(10);

    in_tvalid <= 1'b0;
    guard = 0;
    while (sb.pending.size() != 0 && guard < 5000) begin
      @(posedge clk);
      guard++;
    end
    repeat (8) @(posedge clk);
    if (sb.pending.size() != 0) begin
      $error("%0d results never arrived", sb.pending.size());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
